// ----- hw/rtl/bsc_pkg.sv -----
// ============================================================================
// bsc_pkg
// Shared types, widths and helpers of the Bezier spline control point block.
// ============================================================================
package bsc_pkg;

    localparam int BSC_MAX_POINTS_DEF = 32;
    // Largest point count the block is ever built for; sets the segment field.
    localparam int BSC_MAX_POINTS_TOP = 33;
    localparam int BSC_SEG_W          = $clog2(BSC_MAX_POINTS_TOP);

    localparam int COORD_W = 32;
    localparam int IDX_W   = 6;
    localparam int CFRAC   = 20;
    localparam int GUARD   = 8;
    localparam int SOL_W   = 48;
    localparam int MAG_W   = 44;
    localparam int PIV_W   = 23;
    localparam int CW      = 21;
    localparam int QW      = 44;
    localparam int HALF_W  = MAG_W / 2;
    localparam int ACC_W   = MAG_W + CW;
    localparam int Q_W     = SOL_W + 1 - GUARD;

    localparam int BSC_JOBQ_DEPTH = 2;

    localparam logic [SOL_W-1:0] MAG_LIMIT = SOL_W'(1) << (MAG_W - 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } bsc_point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ctrl_x;
        logic signed [COORD_W-1:0] ctrl_y;
        logic [IDX_W-1:0]          ctrl_index;
        logic                      final_result;
        logic                      error_flag;
    } bsc_result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } bsc_pt_word_t;

    typedef struct packed {
        logic [CW-1:0]           c;
        logic signed [SOL_W-1:0] sx;
        logic signed [SOL_W-1:0] sy;
    } bsc_work_t;

    typedef struct packed {
        logic                 err;
        logic [BSC_SEG_W-1:0] segs;
    } bsc_job_t;

    typedef struct packed {
        logic signed [SOL_W-1:0] vx;
        logic signed [SOL_W-1:0] vy;
        logic                    sh9;
        logic [IDX_W-1:0]        idx;
        logic                    fin;
        logic                    err;
    } bsc_rnd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_F_RD0,
        ST_F_LD0,
        ST_F_RD,
        ST_F_LD,
        ST_F_PREP,
        ST_F_DIV,
        ST_F_WAIT,
        ST_B_RD,
        ST_B_MUL,
        ST_B_WR,
        ST_O_RD,
        ST_O_P1,
        ST_O_P2
    } bsc_state_t;

    // Magnitude of a solution value, clamped to 2^43.
    function automatic logic [MAG_W-1:0] mag_clamp(input logic signed [SOL_W-1:0] v);
        logic [SOL_W-1:0] m;
        m = v[SOL_W-1] ? -v : v;
        if (m > MAG_LIMIT)
        begin
            return MAG_LIMIT[MAG_W-1:0];
        end
        return m[MAG_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/bsc_ram.sv -----
// ============================================================================
// bsc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bsc_ram #(
    parameter int W = 8,
    parameter int D = 32,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/bsc_front.sv -----
// ============================================================================
// bsc_front
// Point loader: stores points, counts them and classifies the closing one.
// ============================================================================
module bsc_front import bsc_pkg::*; #(
    parameter int MAX_POINTS = BSC_MAX_POINTS_DEF,
    localparam int CNT_W = $clog2(MAX_POINTS + 1),
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  bsc_point_t           point,
    output logic                 pt_we,
    output logic [AW-1:0]        pt_waddr,
    output bsc_pt_word_t         pt_wdata,
    output logic                 job_push,
    output bsc_job_t             job
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             has_room;
    logic [CNT_W-1:0] n_total;

    assign has_room = count_reg < CNT_W'(MAX_POINTS);
    assign n_total  = has_room ? count_reg + CNT_W'(1) : count_reg;

    assign pt_we       = accept && has_room;
    assign pt_waddr    = count_reg[AW-1:0];
    assign pt_wdata.x  = point.point_x;
    assign pt_wdata.y  = point.point_y;

    // A closing point with too few or too many points becomes an error job.
    assign job_push = accept && point.last_point;
    assign job.err  = (n_total < CNT_W'(2)) || ovf_reg || !has_room;
    assign job.segs = BSC_SEG_W'(n_total - CNT_W'(1));

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (point.last_point)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (has_room)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ----- hw/rtl/bsc_queue.sv -----
// ============================================================================
// bsc_queue
// Short job queue between the point loader and the solver.
// ============================================================================
module bsc_queue import bsc_pkg::*; #(
    parameter int DEPTH = BSC_JOBQ_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bsc_job_t din,
    input  logic     pop,
    output logic     not_empty,
    output bsc_job_t dout
);

    bsc_job_t      entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   fill_reg;

    assign not_empty = fill_reg != '0;
    assign dout      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (PW + 1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (PW + 1)'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/bsc_div.sv -----
// ============================================================================
// bsc_div
// Bit-serial divider: x and y numerators and the superdiagonal by one pivot.
// ============================================================================
module bsc_div import bsc_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SOL_W-1:0] num_x,
    input  logic signed [SOL_W-1:0] num_y,
    input  logic [PIV_W-1:0]        piv,
    output logic                    done,
    output logic signed [SOL_W-1:0] quo_x,
    output logic signed [SOL_W-1:0] quo_y,
    output logic [CW-1:0]           quo_c
);

    localparam int CNT_W = $clog2(QW);
    localparam int DVD_W = MAG_W + CFRAC;
    localparam logic [DVD_W-1:0] C_DVD = DVD_W'(1) << (2 * CFRAC);

    logic [2:0][PIV_W-1:0] rem_reg, rem_next;
    logic [2:0][QW-1:0]    dvd_reg;
    logic [2:0][QW-1:0]    q_reg;
    logic [2:0]            ge;
    logic [PIV_W-1:0]      piv_reg;
    logic                  neg_x_reg, neg_y_reg;
    logic                  run_reg, done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DVD_W-1:0]      dvd_x, dvd_y;
    logic [PIV_W:0]        t [3];
    logic [PIV_W:0]        diff [3];
    logic signed [SOL_W-1:0] qx_ext, qy_ext;

    assign dvd_x = {mag_clamp(num_x), CFRAC'(0)};
    assign dvd_y = {mag_clamp(num_y), CFRAC'(0)};

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            t[l]        = {rem_reg[l], dvd_reg[l][QW-1]};
            diff[l]     = t[l] - {1'b0, piv_reg};
            ge[l]       = t[l] >= {1'b0, piv_reg};
            rem_next[l] = ge[l] ? diff[l][PIV_W-1:0] : t[l][PIV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            piv_reg    <= piv;
            neg_x_reg  <= num_x[SOL_W-1];
            neg_y_reg  <= num_y[SOL_W-1];
            rem_reg[0] <= PIV_W'(dvd_x[DVD_W-1:QW]);
            rem_reg[1] <= PIV_W'(dvd_y[DVD_W-1:QW]);
            rem_reg[2] <= PIV_W'(C_DVD[DVD_W-1:QW]);
            dvd_reg[0] <= dvd_x[QW-1:0];
            dvd_reg[1] <= dvd_y[QW-1:0];
            dvd_reg[2] <= C_DVD[QW-1:0];
        end
        else if (run_reg)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[l] <= rem_next[l];
                dvd_reg[l] <= {dvd_reg[l][QW-2:0], 1'b0};
                q_reg[l]   <= {q_reg[l][QW-2:0], ge[l]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign qx_ext = {{(SOL_W - QW){1'b0}}, q_reg[0]};
    assign qy_ext = {{(SOL_W - QW){1'b0}}, q_reg[1]};
    assign quo_x  = neg_x_reg ? -qx_ext : qx_ext;
    assign quo_y  = neg_y_reg ? -qy_ext : qy_ext;
    assign quo_c  = q_reg[2][CW-1:0];
    assign done   = done_reg;

endmodule

// ----- hw/rtl/bsc_round.sv -----
// ============================================================================
// bsc_round
// Three-stage result pipeline: magnitude, rounding, saturation.
// ============================================================================
module bsc_round import bsc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bsc_rnd_t    rnd,
    output logic        result_valid,
    output bsc_result_t result
);

    logic             va_reg, vb_reg, vc_reg;
    logic [SOL_W-1:0] mag_x_reg, mag_y_reg;
    logic [Q_W-1:0]   q_x_reg, q_y_reg;
    logic             neg_x_a_reg, neg_y_a_reg, neg_x_b_reg, neg_y_b_reg;
    logic             sh9_a_reg;
    logic [IDX_W-1:0] idx_a_reg, idx_b_reg;
    logic             fin_a_reg, fin_b_reg, err_a_reg, err_b_reg;
    bsc_result_t      result_reg;
    logic [SOL_W:0]   sum_x, sum_y, half;

    function automatic logic [COORD_W-1:0] sat(input logic [Q_W-1:0] q, input logic neg);
        logic [Q_W-1:0] nq;
        nq = -q;
        if (neg)
        begin
            if (q >= Q_W'(33'h080000000))
            begin
                return 32'h80000000;
            end
            return nq[COORD_W-1:0];
        end
        if (q > Q_W'(32'h7FFFFFFF))
        begin
            return 32'h7FFFFFFF;
        end
        return q[COORD_W-1:0];
    endfunction

    assign half  = sh9_a_reg ? (SOL_W + 1)'(1 << GUARD) : (SOL_W + 1)'(1 << (GUARD - 1));
    assign sum_x = {1'b0, mag_x_reg} + half;
    assign sum_y = {1'b0, mag_y_reg} + half;

    always_ff @(posedge clk)
    begin
        mag_x_reg   <= rnd.vx[SOL_W-1] ? -rnd.vx : rnd.vx;
        mag_y_reg   <= rnd.vy[SOL_W-1] ? -rnd.vy : rnd.vy;
        neg_x_a_reg <= rnd.vx[SOL_W-1];
        neg_y_a_reg <= rnd.vy[SOL_W-1];
        sh9_a_reg   <= rnd.sh9;
        idx_a_reg   <= rnd.idx;
        fin_a_reg   <= rnd.fin;
        err_a_reg   <= rnd.err;

        q_x_reg     <= sh9_a_reg ? Q_W'(sum_x[SOL_W:GUARD+1]) : sum_x[SOL_W:GUARD];
        q_y_reg     <= sh9_a_reg ? Q_W'(sum_y[SOL_W:GUARD+1]) : sum_y[SOL_W:GUARD];
        neg_x_b_reg <= neg_x_a_reg;
        neg_y_b_reg <= neg_y_a_reg;
        idx_b_reg   <= idx_a_reg;
        fin_b_reg   <= fin_a_reg;
        err_b_reg   <= err_a_reg;

        result_reg.ctrl_x       <= sat(q_x_reg, neg_x_b_reg);
        result_reg.ctrl_y       <= sat(q_y_reg, neg_y_b_reg);
        result_reg.ctrl_index   <= idx_b_reg;
        result_reg.final_result <= fin_b_reg;
        result_reg.error_flag   <= err_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= push;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    assign result_valid = vc_reg;
    assign result       = result_reg;

endmodule

// ----- hw/rtl/bsc_back.sv -----
// ============================================================================
// bsc_back
// Solver sequencer: forward sweep, back substitution and result emission.
// ============================================================================
module bsc_back import bsc_pkg::*; #(
    parameter int MAX_POINTS = BSC_MAX_POINTS_DEF,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  bsc_job_t      job,
    output logic          job_pop,
    output logic          active,
    output logic          pt_re,
    output logic [AW-1:0] pt_raddr,
    input  bsc_pt_word_t  pt_rdata,
    output logic          rnd_push,
    output bsc_rnd_t      rnd
);

    bsc_state_t state_reg, state_next;

    logic [AW-1:0]            row_reg;
    logic [BSC_SEG_W-1:0]     segs_reg;
    logic signed [COORD_W-1:0] k_cur_x_reg, k_cur_y_reg, k_nxt_x_reg, k_nxt_y_reg;
    logic [CW-1:0]            prev_c_reg;
    logic signed [SOL_W-1:0]  cur_x_reg, cur_y_reg;
    logic signed [SOL_W-1:0]  num_x_reg, num_y_reg;
    logic [PIV_W-1:0]         piv_reg;
    logic [MAG_W-1:0]         mag_x_reg, mag_y_reg;
    logic                     neg_x_reg, neg_y_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [1:0]               step_reg;
    logic signed [SOL_W-1:0]  new_x_reg;
    logic signed [SOL_W-1:0]  p2_x_reg, p2_y_reg;
    logic                     p2_sh9_reg;

    logic                     is_last, row_zero;
    logic [AW-1:0]            row_p1, row_m1;
    logic                     wk_we, wk_re;
    logic [AW-1:0]            wk_waddr, wk_raddr;
    bsc_work_t                wk_wdata, wk_rdata;
    logic                     div_start, div_done;
    logic signed [SOL_W-1:0]  quo_x, quo_y;
    logic [CW-1:0]            quo_c, c_sel;

    logic signed [SOL_W-1:0]  kx, ky, knx, kny, rhs_x, rhs_y, num_x, num_y;
    logic [PIV_W-1:0]         piv;
    logic [HALF_W-1:0]        mul_op;
    logic [HALF_W+CW-1:0]     mul_p;
    logic signed [SOL_W-1:0]  prod_s, corr, new_val;
    logic signed [SOL_W-1:0]  pkx, pky, p2_x, p2_y;

    assign is_last  = (BSC_SEG_W'(row_reg) + BSC_SEG_W'(1)) == segs_reg;
    assign row_zero = row_reg == '0;
    assign row_p1   = row_reg + AW'(1);
    assign row_m1   = row_reg - AW'(1);
    assign c_sel    = is_last ? '0 : quo_c;
    assign active   = state_reg != ST_IDLE;

    bsc_ram #(.W($bits(bsc_work_t)), .D(MAX_POINTS)) u_work (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wk_waddr),
        .wdata (wk_wdata),
        .re    (wk_re),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

    bsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_x (num_x_reg),
        .num_y (num_y_reg),
        .piv   (piv_reg),
        .done  (div_done),
        .quo_x (quo_x),
        .quo_y (quo_y),
        .quo_c (quo_c)
    );

    // Right-hand side and pivot of the current row of the system.
    always_comb
    begin
        kx  = SOL_W'(k_cur_x_reg);
        ky  = SOL_W'(k_cur_y_reg);
        knx = SOL_W'(k_nxt_x_reg);
        kny = SOL_W'(k_nxt_y_reg);
        priority if (is_last)
        begin
            rhs_x = (kx <<< 3) + knx;
            rhs_y = (ky <<< 3) + kny;
            piv   = PIV_W'(7) << CFRAC;
        end
        else if (row_zero)
        begin
            rhs_x = kx + (knx <<< 1);
            rhs_y = ky + (kny <<< 1);
            piv   = PIV_W'(2) << CFRAC;
        end
        else
        begin
            rhs_x = (kx <<< 2) + (knx <<< 1);
            rhs_y = (ky <<< 2) + (kny <<< 1);
            piv   = PIV_W'(4) << CFRAC;
        end
        num_x = rhs_x <<< GUARD;
        num_y = rhs_y <<< GUARD;
        if (!row_zero)
        begin
            if (is_last)
            begin
                num_x = num_x - (cur_x_reg <<< 1);
                num_y = num_y - (cur_y_reg <<< 1);
                piv   = piv - (PIV_W'(prev_c_reg) << 1);
            end
            else
            begin
                num_x = num_x - cur_x_reg;
                num_y = num_y - cur_y_reg;
                piv   = piv - PIV_W'(prev_c_reg);
            end
        end
    end

    // Back substitution: c' times the clamped magnitude in two halves per axis.
    always_comb
    begin
        unique case (step_reg)
            2'd0:    mul_op = mag_x_reg[HALF_W-1:0];
            2'd1:    mul_op = mag_x_reg[MAG_W-1:HALF_W];
            2'd2:    mul_op = mag_y_reg[HALF_W-1:0];
            default: mul_op = mag_y_reg[MAG_W-1:HALF_W];
        endcase
        mul_p   = mul_op * wk_rdata.c;
        prod_s  = SOL_W'(acc_reg[ACC_W-1:CFRAC]);
        if (state_reg == ST_B_WR)
        begin
            corr    = neg_y_reg ? -prod_s : prod_s;
            new_val = wk_rdata.sy - corr;
        end
        else
        begin
            corr    = neg_x_reg ? -prod_s : prod_s;
            new_val = wk_rdata.sx - corr;
        end
    end

    // Second control point of the current segment.
    always_comb
    begin
        pkx = SOL_W'(pt_rdata.x);
        pky = SOL_W'(pt_rdata.y);
        if (is_last)
        begin
            p2_x = (pkx <<< GUARD) + cur_x_reg;
            p2_y = (pky <<< GUARD) + cur_y_reg;
        end
        else
        begin
            p2_x = (pkx <<< (GUARD + 1)) - wk_rdata.sx;
            p2_y = (pky <<< (GUARD + 1)) - wk_rdata.sy;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.err ? ST_ERR : ST_F_RD0;
                end
            end
            ST_ERR:    state_next = ST_IDLE;
            ST_F_RD0:  state_next = ST_F_LD0;
            ST_F_LD0:  state_next = ST_F_RD;
            ST_F_RD:   state_next = ST_F_LD;
            ST_F_LD:   state_next = ST_F_PREP;
            ST_F_PREP: state_next = ST_F_DIV;
            ST_F_DIV:  state_next = ST_F_WAIT;
            ST_F_WAIT:
            begin
                if (div_done)
                begin
                    priority if (!is_last)
                    begin
                        state_next = ST_F_RD;
                    end
                    else if (row_zero)
                    begin
                        state_next = ST_O_RD;
                    end
                    else
                    begin
                        state_next = ST_B_RD;
                    end
                end
            end
            ST_B_RD:   state_next = ST_B_MUL;
            ST_B_MUL:  state_next = (step_reg == 2'd3) ? ST_B_WR : ST_B_MUL;
            ST_B_WR:   state_next = (row_reg == AW'(1)) ? ST_O_RD : ST_B_RD;
            ST_O_RD:   state_next = ST_O_P1;
            ST_O_P1:   state_next = ST_O_P2;
            ST_O_P2:   state_next = is_last ? ST_IDLE : ST_O_RD;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop   = 1'b0;
        pt_re     = 1'b0;
        pt_raddr  = row_p1;
        wk_re     = 1'b0;
        wk_raddr  = row_p1;
        wk_we     = 1'b0;
        wk_waddr  = row_reg;
        wk_wdata  = '{c: c_sel, sx: quo_x, sy: quo_y};
        div_start = 1'b0;
        rnd_push  = 1'b0;
        rnd       = '{vx: cur_x_reg, vy: cur_y_reg, sh9: 1'b0,
                      idx: IDX_W'({row_reg, 1'b0}), fin: 1'b0, err: 1'b0};
        unique case (state_reg)
            ST_IDLE:   job_pop = job_valid;
            ST_ERR:
            begin
                rnd_push = 1'b1;
                rnd      = '{vx: '0, vy: '0, sh9: 1'b0, idx: '0, fin: 1'b1, err: 1'b1};
            end
            ST_F_RD0:
            begin
                pt_re    = 1'b1;
                pt_raddr = '0;
            end
            ST_F_RD:   pt_re = 1'b1;
            ST_F_DIV:  div_start = 1'b1;
            ST_F_WAIT: wk_we = div_done;
            ST_B_RD:
            begin
                wk_re    = 1'b1;
                wk_raddr = row_m1;
            end
            ST_B_WR:
            begin
                wk_we    = 1'b1;
                wk_waddr = row_m1;
                wk_wdata = '{c: wk_rdata.c, sx: new_x_reg, sy: new_val};
            end
            ST_O_RD:
            begin
                pt_re = 1'b1;
                wk_re = !is_last;
            end
            ST_O_P1:   rnd_push = 1'b1;
            ST_O_P2:
            begin
                rnd_push = 1'b1;
                rnd      = '{vx: p2_x_reg, vy: p2_y_reg, sh9: p2_sh9_reg,
                             idx: IDX_W'({row_reg, 1'b1}), fin: is_last, err: 1'b0};
            end
            default:   job_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                segs_reg <= job.segs;
                row_reg  <= '0;
            end
            ST_F_LD0:
            begin
                k_cur_x_reg <= pt_rdata.x;
                k_cur_y_reg <= pt_rdata.y;
            end
            ST_F_LD:
            begin
                k_nxt_x_reg <= pt_rdata.x;
                k_nxt_y_reg <= pt_rdata.y;
            end
            ST_F_PREP:
            begin
                num_x_reg <= num_x;
                num_y_reg <= num_y;
                piv_reg   <= piv;
            end
            ST_F_WAIT:
            begin
                if (div_done)
                begin
                    prev_c_reg  <= c_sel;
                    cur_x_reg   <= quo_x;
                    cur_y_reg   <= quo_y;
                    k_cur_x_reg <= k_nxt_x_reg;
                    k_cur_y_reg <= k_nxt_y_reg;
                    if (!is_last)
                    begin
                        row_reg <= row_p1;
                    end
                end
            end
            ST_B_RD:
            begin
                mag_x_reg <= mag_clamp(cur_x_reg);
                mag_y_reg <= mag_clamp(cur_y_reg);
                neg_x_reg <= cur_x_reg[SOL_W-1];
                neg_y_reg <= cur_y_reg[SOL_W-1];
                step_reg  <= 2'd0;
            end
            ST_B_MUL:
            begin
                step_reg <= step_reg + 2'd1;
                unique case (step_reg)
                    2'd0: acc_reg <= ACC_W'(mul_p);
                    2'd1: acc_reg <= acc_reg + (ACC_W'(mul_p) << HALF_W);
                    2'd2:
                    begin
                        new_x_reg <= new_val;
                        acc_reg   <= ACC_W'(mul_p);
                    end
                    default: acc_reg <= acc_reg + (ACC_W'(mul_p) << HALF_W);
                endcase
            end
            ST_B_WR:
            begin
                cur_x_reg <= new_x_reg;
                cur_y_reg <= new_val;
                row_reg   <= row_m1;
            end
            ST_O_P1:
            begin
                p2_x_reg   <= p2_x;
                p2_y_reg   <= p2_y;
                p2_sh9_reg <= is_last;
                if (!is_last)
                begin
                    cur_x_reg <= wk_rdata.sx;
                    cur_y_reg <= wk_rdata.sy;
                end
            end
            ST_O_P2:
            begin
                if (!is_last)
                begin
                    row_reg <= row_p1;
                end
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

endmodule

// ----- hw/rtl/bezier_spline_control_points_top.sv -----
// ============================================================================
// bezier_spline_control_points_top
// Control points of a smooth cubic Bezier spline through a set of points.
// ============================================================================
// Usage:
// Points enter as transactions on start/busy: a point is taken at a rising
// edge with start high and busy low. Points load one per cycle into the
// point store until one carries last_point, which closes the set.
// The closing transaction starts a solve of the tridiagonal system by the
// Thomas algorithm; busy stays high until the sequencer has passed the last
// result to the three-stage output pipeline.
// The forward sweep of each row is dominated by the 44-step bit-serial
// divider that serves x, y and the superdiagonal together; back substitution
// works through one 22x21 multiplier in two halves per axis, and emission
// reads the stores and pushes P1 and P2 for each segment.
// Results come out as transactions on result_valid, one cycle each, after the
// magnitude, rounding and saturation registers, in the order P1, P2 per segment.
// An invalid set (fewer than two points, or more than MAX_POINTS) yields
// one error transaction. The receiver cannot stall; results are never held.
// Reset clears the point count, the overflow flag, the job queue and the
// sequencer; the stores need no clearing, since a run writes before it reads.
// ============================================================================
module bezier_spline_control_points_top import bsc_pkg::*; #(
    parameter int MAX_POINTS = BSC_MAX_POINTS_DEF,
    localparam int AW = $clog2(MAX_POINTS)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  bsc_point_t  point,
    output logic        result_valid,
    output bsc_result_t result
);

    logic          accept;
    logic          pt_we, pt_re;
    logic [AW-1:0] pt_waddr, pt_raddr;
    bsc_pt_word_t  pt_wdata, pt_rdata;
    logic          job_push, job_pop, job_valid;
    bsc_job_t      job_in, job_out;
    logic          back_active;
    logic          rnd_push;
    bsc_rnd_t      rnd;

    // The point store is shared, so no new point is taken while a job waits
    // in the queue or the solver is still reading the store.
    assign busy   = job_valid || back_active;
    assign accept = start && !busy;

    bsc_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .point    (point),
        .pt_we    (pt_we),
        .pt_waddr (pt_waddr),
        .pt_wdata (pt_wdata),
        .job_push (job_push),
        .job      (job_in)
    );

    bsc_ram #(.W($bits(bsc_pt_word_t)), .D(MAX_POINTS)) u_points (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    bsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .din       (job_in),
        .pop       (job_pop),
        .not_empty (job_valid),
        .dout      (job_out)
    );

    bsc_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .active    (back_active),
        .pt_re     (pt_re),
        .pt_raddr  (pt_raddr),
        .pt_rdata  (pt_rdata),
        .rnd_push  (rnd_push),
        .rnd       (rnd)
    );

    bsc_round u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (rnd_push),
        .rnd          (rnd),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
